// ===== rtl/core/fbcf_pkg.sv =====
// Package: payload types, register indexes and constants for the fading blend / colour floor block.
`default_nettype none
package fbcf_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [ChanWidth-1:0] RampStep = 8'd5;
   localparam logic [ChanWidth-1:0] FloorThreshold = 8'd20;
   localparam logic [ChanWidth-1:0] FullScale = 8'd255;

   localparam logic [CsrIndexWidth-1:0] CSR_EFFECT_MODE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_COLOR_SELECT = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RAMP_ENABLE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_INTENSITY = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_START_INTENSITY = 3'd4;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic MODE_BLEND = 1'b0;
   localparam logic MODE_FLOOR = 1'b1;

   localparam logic [1:0] SEL_RED = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE = 2'd2;
   localparam logic [1:0] SEL_ALL = 2'd3;

   typedef struct packed {
      logic                 cmd;
      logic [ChanWidth-1:0] cam_blue;
      logic [ChanWidth-1:0] cam_green;
      logic [ChanWidth-1:0] cam_red;
      logic [ChanWidth-1:0] ovl_blue;
      logic [ChanWidth-1:0] ovl_green;
      logic [ChanWidth-1:0] ovl_red;
      logic                 overlay_valid;
   } req_type;

   typedef struct packed {
      logic [ChanWidth-1:0] out_blue;
      logic [ChanWidth-1:0] out_green;
      logic [ChanWidth-1:0] out_red;
   } rsp_type;

   typedef struct packed {
      logic blend;
      logic floor_en;
   } chan_ctl_type;

   // Truncating divide by 255 of a product of two bytes.
   function automatic logic [ChanWidth-1:0] div_full_scale(input logic [2*ChanWidth-1:0] x);
      logic [2*ChanWidth:0] t;
      t = {1'b0, x} + {{(ChanWidth+1){1'b0}}, x[2*ChanWidth-1:ChanWidth]}
          + {{(2*ChanWidth){1'b0}}, 1'b1};
      return t[2*ChanWidth-1:ChanWidth];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fbcf_chan.sv =====
// Per-channel datapath: crossfade of camera and overlay, or colour floor by intensity.
`default_nettype none
module fbcf_chan (
   input  wire logic [fbcf_pkg::ChanWidth-1:0] cam,
   input  wire logic [fbcf_pkg::ChanWidth-1:0] ovl,
   input  wire logic [fbcf_pkg::ChanWidth-1:0] intensity,
   input  wire fbcf_pkg::chan_ctl_type         ctl,
   output logic      [fbcf_pkg::ChanWidth-1:0] result
);
   import fbcf_pkg::*;

   logic [2*ChanWidth-1:0] cam_prod;
   logic [2*ChanWidth-1:0] ovl_prod;
   logic [ChanWidth-1:0]   blended;

   assign cam_prod = cam * (FullScale - intensity);
   assign ovl_prod = ovl * intensity;
   assign blended = div_full_scale(cam_prod) + div_full_scale(ovl_prod);

   always_comb begin
      if (ctl.blend) begin
         result = blended;
      end else if (ctl.floor_en && (cam < intensity)) begin
         result = intensity;
      end else begin
         result = cam;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/fading_blend_color_floor_pixel.sv =====
// Top level: ramped-intensity crossfade and colour-floor effect on an RGB pixel stream.
//
// Usage:
//   req_*  carries items. cmd = tick steps the running intensity 5 toward
//          max_intensity (when ramp_enable is set) and gives no result;
//          cmd = pixel gives exactly one rsp_* transfer.
//   rsp_*  carries the resulting RGB pixel, in item order.
//   csr_*  writes a register by index; always ready. Indexes beyond the
//          list are ignored. Writing start_intensity also loads the
//          running intensity. Write only while the block is idle.
// Pipeline: a pixel passes two register stages, input register then result
//   register, before it is shown on rsp_*.
// Throughput: one item per cycle unless rsp_* stalls; a tick updates the intensity
//   at its transfer, so a pixel in the next cycle already sees the new value.
// Reset: synchronous; clears both stages, running intensity and registers
//   (color_select to all three channels).
// Stall: while rsp_ready is low the result holds; the input register still
//   takes one more pixel, then req_ready drops until the result moves.
`default_nettype none
module fading_blend_color_floor_pixel (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire fbcf_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output fbcf_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [fbcf_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [fbcf_pkg::ChanWidth-1:0]        csr_data
);
   import fbcf_pkg::*;

   logic                 effect_mode_ff;
   logic [1:0]           color_select_ff;
   logic                 ramp_enable_ff;
   logic [ChanWidth-1:0] max_intensity_ff;
   logic [ChanWidth-1:0] intensity_ff;
   logic [ChanWidth-1:0] intensity_in;

   logic                 stage_valid_ff;
   req_type              stage_data_ff;
   logic [ChanWidth-1:0] stage_intensity_ff;

   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 stage_advance;
   logic                 stage_load;
   logic [ChanWidth:0]   ramp_up;
   logic [ChanWidth:0]   ramp_floor;
   logic                 blend_on;
   logic                 floor_on;
   chan_ctl_type         ctl_red;
   chan_ctl_type         ctl_green;
   chan_ctl_type         ctl_blue;

   assign csr_ready = 1'b1;
   assign csr_xfer = csr_valid && csr_ready;

   assign stage_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !stage_valid_ff || stage_advance;
   assign req_xfer = req_valid && req_ready;
   assign stage_load = req_xfer && (req_data.cmd == CMD_PIXEL);

   assign ramp_up = {1'b0, intensity_ff} + {1'b0, RampStep};
   assign ramp_floor = {1'b0, max_intensity_ff} + {1'b0, RampStep};

   always_comb begin
      intensity_in = intensity_ff;
      if (csr_xfer && (csr_index == CSR_START_INTENSITY)) begin
         intensity_in = csr_data;
      end else if (req_xfer && (req_data.cmd == CMD_TICK) && ramp_enable_ff) begin
         if (intensity_ff < max_intensity_ff) begin
            if (ramp_up > {1'b0, max_intensity_ff}) begin
               intensity_in = max_intensity_ff;
            end else begin
               intensity_in = ramp_up[ChanWidth-1:0];
            end
         end else if ({1'b0, intensity_ff} >= ramp_floor) begin
            intensity_in = intensity_ff - RampStep;
         end else begin
            intensity_in = max_intensity_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_mode_ff <= MODE_BLEND;
         color_select_ff <= SEL_ALL;
         ramp_enable_ff <= 1'b0;
         max_intensity_ff <= '0;
         intensity_ff <= '0;
      end else begin
         intensity_ff <= intensity_in;
         if (csr_xfer) begin
            case (csr_index)
               CSR_EFFECT_MODE: begin
                  effect_mode_ff <= csr_data[0];
               end
               CSR_COLOR_SELECT: begin
                  color_select_ff <= csr_data[1:0];
               end
               CSR_RAMP_ENABLE: begin
                  ramp_enable_ff <= csr_data[0];
               end
               CSR_MAX_INTENSITY: begin
                  max_intensity_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Input register: hold while it is full and the result register is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= stage_load;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         stage_data_ff <= req_data;
         stage_intensity_ff <= intensity_ff;
      end
   end

   assign blend_on = (effect_mode_ff == MODE_BLEND) && stage_data_ff.overlay_valid;
   assign floor_on = (effect_mode_ff == MODE_FLOOR) && (stage_intensity_ff > FloorThreshold);

   assign ctl_red = '{blend: blend_on,
                      floor_en: floor_on && (color_select_ff inside {SEL_RED, SEL_ALL})};
   assign ctl_green = '{blend: blend_on,
                        floor_en: floor_on && (color_select_ff inside {SEL_GREEN, SEL_ALL})};
   assign ctl_blue = '{blend: blend_on,
                       floor_en: floor_on && (color_select_ff inside {SEL_BLUE, SEL_ALL})};

   fbcf_chan u_chan_red (
      .cam       (stage_data_ff.cam_red),
      .ovl       (stage_data_ff.ovl_red),
      .intensity (stage_intensity_ff),
      .ctl       (ctl_red),
      .result    (rsp_data_in.out_red)
   );

   fbcf_chan u_chan_green (
      .cam       (stage_data_ff.cam_green),
      .ovl       (stage_data_ff.ovl_green),
      .intensity (stage_intensity_ff),
      .ctl       (ctl_green),
      .result    (rsp_data_in.out_green)
   );

   fbcf_chan u_chan_blue (
      .cam       (stage_data_ff.cam_blue),
      .ovl       (stage_data_ff.ovl_blue),
      .intensity (stage_intensity_ff),
      .ctl       (ctl_blue),
      .result    (rsp_data_in.out_blue)
   );

   // Result register: advance when empty or when the current transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_advance) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_advance && stage_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire
